// ===== hdl/tbpc_pkg.sv =====
// Shared types, constants and tables of the tilt balance PID controller.
// Used by the register file, the sequencer and the datapath.
`default_nettype none

package tbpc_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam int ITER_W       = 5;

    // The filter divide: reciprocal estimate, back-multiply, one correction.
    localparam int DIV_STEPS    = 3;
    localparam int DIV_K        = 1310000;
    localparam int DIV_HALF     = DIV_K / 2;

    // floor(m / DIV_K) is ((m >> 16) * DIV_RECIP) >> 24 or one more, for m below 2^36.
    localparam int DIV_RECIP    = 839321;
    localparam int DIV_RECIP_SH = 24;

    localparam int PITCH_MAX    = 46080;
    localparam int INTEG_MAX    = 38400;
    localparam int DEG180       = 11796480;

    // floor(m / 50) == (m * RECIP50) >> 23 for every m below 2^17.
    localparam int RECIP50      = 167773;
    localparam int RECIP50_SH   = 23;

    localparam int ADDR_W       = 5;

    localparam logic [2:0] REG_GYRO_OFFSET   = 3'd0;
    localparam logic [2:0] REG_SETPOINT      = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN     = 3'd2;
    localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd3;
    localparam logic [2:0] REG_DERIV_GAIN    = 3'd4;
    localparam logic [2:0] REG_FALL_LIMIT    = 3'd5;
    localparam logic [2:0] REG_RECOVER_LIMIT = 3'd6;
    localparam logic [2:0] REG_DEAD_BAND     = 3'd7;

    localparam logic [1:0] DIR_BRAKE   = 2'd0;
    localparam logic [1:0] DIR_FORWARD = 2'd1;
    localparam logic [1:0] DIR_REVERSE = 2'd2;

    typedef struct packed {
        logic [15:0] gyro_offset;
        logic [16:0] setpoint;
        logic [15:0] prop_gain;
        logic [15:0] integral_gain;
        logic [15:0] deriv_gain;
        logic [15:0] fall_limit;
        logic [15:0] recover_limit;
        logic [7:0]  dead_band;
    } cfg_t;

    typedef enum logic [4:0] {
        STEP_NOP, STEP_LOAD, STEP_CORDIC, STEP_ACC, STEP_F1, STEP_F2, STEP_F3,
        STEP_F4, STEP_DIV, STEP_PITCH, STEP_SAFE, STEP_P1, STEP_P2, STEP_P3,
        STEP_P4, STEP_P5, STEP_P6, STEP_OUT
    } step_t;

    typedef struct packed {
        step_t             step;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

    // atan(2^-i) in 1/65536 degree, rounded to nearest.
    function automatic logic [21:0] atan_angle(input logic [ITER_W-1:0] idx);
        logic [21:0] v;
        begin
            case (idx)
                5'd0:    v = 22'd2949120;
                5'd1:    v = 22'd1740967;
                5'd2:    v = 22'd919879;
                5'd3:    v = 22'd466945;
                5'd4:    v = 22'd234379;
                5'd5:    v = 22'd117304;
                5'd6:    v = 22'd58666;
                5'd7:    v = 22'd29335;
                5'd8:    v = 22'd14668;
                5'd9:    v = 22'd7334;
                5'd10:   v = 22'd3667;
                5'd11:   v = 22'd1833;
                5'd12:   v = 22'd917;
                5'd13:   v = 22'd458;
                5'd14:   v = 22'd229;
                5'd15:   v = 22'd115;
                5'd16:   v = 22'd57;
                5'd17:   v = 22'd29;
                5'd18:   v = 22'd14;
                5'd19:   v = 22'd7;
                5'd20:   v = 22'd4;
                5'd21:   v = 22'd2;
                5'd22:   v = 22'd1;
                default: v = 22'd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tbpc_cfg_regs.sv =====
// Configuration register file with an APB-style port.
// Depends on tbpc_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module tbpc_cfg_regs
    import tbpc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t        cfg_reg;
    logic [2:0]  idx;
    logic        wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gyro_offset   <= 16'd0;
            cfg_reg.setpoint      <= 17'h1FC00;
            cfg_reg.prop_gain     <= 16'd23040;
            cfg_reg.integral_gain <= 16'd1280;
            cfg_reg.deriv_gain    <= 16'd0;
            cfg_reg.fall_limit    <= 16'd7680;
            cfg_reg.recover_limit <= 16'd3840;
            cfg_reg.dead_band     <= 8'd210;
        end else if (wr_en) begin
            case (idx)
                REG_GYRO_OFFSET:   cfg_reg.gyro_offset   <= pwdata[15:0];
                REG_SETPOINT:      cfg_reg.setpoint      <= pwdata[16:0];
                REG_PROP_GAIN:     cfg_reg.prop_gain     <= pwdata[15:0];
                REG_INTEGRAL_GAIN: cfg_reg.integral_gain <= pwdata[15:0];
                REG_DERIV_GAIN:    cfg_reg.deriv_gain    <= pwdata[15:0];
                REG_FALL_LIMIT:    cfg_reg.fall_limit    <= pwdata[15:0];
                REG_RECOVER_LIMIT: cfg_reg.recover_limit <= pwdata[15:0];
                REG_DEAD_BAND:     cfg_reg.dead_band     <= pwdata[7:0];
                default:           cfg_reg.dead_band     <= cfg_reg.dead_band;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_GYRO_OFFSET:   prdata = {16'd0, cfg_reg.gyro_offset};
            REG_SETPOINT:      prdata = {15'd0, cfg_reg.setpoint};
            REG_PROP_GAIN:     prdata = {16'd0, cfg_reg.prop_gain};
            REG_INTEGRAL_GAIN: prdata = {16'd0, cfg_reg.integral_gain};
            REG_DERIV_GAIN:    prdata = {16'd0, cfg_reg.deriv_gain};
            REG_FALL_LIMIT:    prdata = {16'd0, cfg_reg.fall_limit};
            REG_RECOVER_LIMIT: prdata = {16'd0, cfg_reg.recover_limit};
            REG_DEAD_BAND:     prdata = {24'd0, cfg_reg.dead_band};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tbpc_ctrl.sv =====
// Sequencer of the tilt balance controller: walks one sample through the
// datapath steps. Depends on tbpc_pkg for the command and status types.
`default_nettype none

module tbpc_ctrl
    import tbpc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_tvalid,
    output logic         s_tready,
    input  status_t      status,
    output cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_CORDIC, S_ACC, S_F1, S_F2, S_F3, S_F4, S_DIV, S_PITCH,
        S_SAFE, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_OUT
    } state_t;

    state_t            state_reg;
    logic [ITER_W-1:0] cnt_reg;

    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    cnt_reg <= '0;
                    if (s_tvalid) begin
                        state_reg <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (cnt_reg == ITER_W'(CORDIC_ITERS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_ACC;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_ACC:   state_reg <= S_F1;
                S_F1:    state_reg <= S_F2;
                S_F2:    state_reg <= S_F3;
                S_F3:    state_reg <= S_F4;
                S_F4:    state_reg <= S_DIV;
                S_DIV: begin
                    if (cnt_reg == ITER_W'(DIV_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= S_PITCH;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PITCH: state_reg <= S_SAFE;
                S_SAFE:  state_reg <= S_P1;
                S_P1:    state_reg <= S_P2;
                S_P2:    state_reg <= S_P3;
                S_P3:    state_reg <= S_P4;
                S_P4:    state_reg <= S_P5;
                S_P5:    state_reg <= S_P6;
                S_P6:    state_reg <= S_OUT;
                S_OUT: begin
                    if (status.out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        cmd.iter = cnt_reg;
        case (state_reg)
            S_IDLE:   cmd.step = s_tvalid ? STEP_LOAD : STEP_NOP;
            S_CORDIC: cmd.step = STEP_CORDIC;
            S_ACC:    cmd.step = STEP_ACC;
            S_F1:     cmd.step = STEP_F1;
            S_F2:     cmd.step = STEP_F2;
            S_F3:     cmd.step = STEP_F3;
            S_F4:     cmd.step = STEP_F4;
            S_DIV:    cmd.step = STEP_DIV;
            S_PITCH:  cmd.step = STEP_PITCH;
            S_SAFE:   cmd.step = STEP_SAFE;
            S_P1:     cmd.step = STEP_P1;
            S_P2:     cmd.step = STEP_P2;
            S_P3:     cmd.step = STEP_P3;
            S_P4:     cmd.step = STEP_P4;
            S_P5:     cmd.step = STEP_P5;
            S_P6:     cmd.step = STEP_P6;
            S_OUT:    cmd.step = status.out_free ? STEP_OUT : STEP_NOP;
            default:  cmd.step = STEP_NOP;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/tbpc_datapath.sv =====
// Datapath of the tilt balance controller: CORDIC atan2, complementary
// filter with a reciprocal-multiply divide, safety lock, PID on one shared
// multiplier, and the result register. Depends on tbpc_pkg.
`default_nettype none

module tbpc_datapath
    import tbpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  cmd_t             cmd,
    input  cfg_t             cfg,
    input  wire logic [15:0] accel_x,
    input  wire logic [15:0] accel_z,
    input  wire logic [15:0] gyro_y,
    input  wire logic        sample_ok,
    input  wire logic        motor_enable,
    input  wire logic        m_tready,
    output logic             m_tvalid,
    output logic [16:0]      pitch_angle,
    output logic             locked,
    output logic [7:0]       duty,
    output logic [1:0]       direction,
    output status_t          status
);

    // Kept state
    logic signed [16:0] pitch_reg;
    logic signed [16:0] integ_reg;
    logic signed [17:0] last_err_reg;
    logic               lock_reg;
    logic               enable_seen_reg;

    // Per-sample working registers
    logic               ok_reg, en_reg, hold_reg;
    logic signed [16:0] g_reg;
    logic signed [18:0] cx_reg, cy_reg;
    logic signed [25:0] cz_reg;
    logic signed [16:0] acc_reg;
    logic signed [43:0] prod_reg;
    logic signed [31:0] d1_reg;
    logic signed [39:0] nacc_reg, n_reg;
    logic        [39:0] rem_reg;
    logic        [17:0] quo_reg;
    logic               nneg_reg;
    logic signed [17:0] e_reg;
    logic        [17:0] emag_reg;
    logic               eneg_reg;
    logic signed [18:0] de_reg;
    logic signed [22:0] kd50_reg;
    logic signed [43:0] sacc_reg;

    // Result register
    logic               m_valid_reg;
    logic [16:0]        out_pitch_reg;
    logic               out_lock_reg;
    logic [7:0]         out_duty_reg;
    logic [1:0]         out_dir_reg;

    // Quotient estimate taken from the product register.
    logic        [17:0] q_est;
    assign q_est = prod_reg[DIV_RECIP_SH+17:DIV_RECIP_SH];

    // Shared multiplier
    logic signed [33:0] mul_a;
    logic signed [22:0] mul_b;
    logic signed [56:0] mul_p;

    always_comb begin
        case (cmd.step)
            STEP_ACC: begin
                mul_a = 34'(pitch_reg);
                mul_b = 23'sd13100;
            end
            STEP_F1: begin
                mul_a = 34'(acc_reg);
                mul_b = 23'sd26200;
            end
            STEP_F2: begin
                mul_a = 34'(d1_reg);
                mul_b = 23'sd98;
            end
            STEP_DIV: begin
                if (cmd.iter == '0) begin
                    mul_a = 34'($signed({1'b0, rem_reg[35:16]}));
                    mul_b = 23'(DIV_RECIP);
                end else begin
                    mul_a = 34'($signed({1'b0, q_est}));
                    mul_b = 23'(DIV_K);
                end
            end
            STEP_P1: begin
                mul_a = 34'(e_reg);
                mul_b = 23'($signed({1'b0, cfg.prop_gain}));
            end
            STEP_P2: begin
                mul_a = 34'($signed({1'b0, emag_reg}));
                mul_b = 23'(RECIP50);
            end
            STEP_P3: begin
                mul_a = 34'($signed({1'b0, cfg.deriv_gain}));
                mul_b = 23'sd50;
            end
            STEP_P4: begin
                mul_a = 34'(integ_reg);
                mul_b = 23'($signed({1'b0, cfg.integral_gain}));
            end
            STEP_P5: begin
                mul_a = 34'(de_reg);
                mul_b = kd50_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // CORDIC micro-rotation
    logic signed [18:0] xs, ys;
    logic signed [25:0] atan_s;
    assign xs     = cx_reg >>> cmd.iter;
    assign ys     = cy_reg >>> cmd.iter;
    assign atan_s = $signed({4'd0, atan_angle(cmd.iter)});

    // Accelerometer angle: round to 1/256 degree, negate, clamp.
    logic signed [25:0] z_rnd;
    logic signed [18:0] acc_neg;
    logic signed [16:0] acc_clamped;
    assign z_rnd   = cz_reg + 26'sd128;
    assign acc_neg = -(19'($signed(z_rnd[25:8])));
    always_comb begin
        if (acc_neg > 19'sd46080) begin
            acc_clamped = 17'sd46080;
        end else if (acc_neg < -19'sd46080) begin
            acc_clamped = -17'sd46080;
        end else begin
            acc_clamped = 17'(acc_neg);
        end
    end

    // Divider signals
    logic [39:0] n_abs;
    assign n_abs = n_reg[39] ? 40'(-n_reg) : 40'(n_reg);

    logic signed [18:0] q_signed;
    logic signed [16:0] pitch_new;
    assign q_signed = nneg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    always_comb begin
        if (q_signed > 19'sd46080) begin
            pitch_new = 17'sd46080;
        end else if (q_signed < -19'sd46080) begin
            pitch_new = -17'sd46080;
        end else begin
            pitch_new = 17'(q_signed);
        end
    end

    // Safety terms
    logic signed [17:0] setp_s;
    logic        [16:0] pitch_abs;
    logic signed [18:0] pdiff;
    logic        [17:0] pdiff_abs;
    assign setp_s    = 18'($signed(cfg.setpoint));
    assign pitch_abs = pitch_reg[16] ? 17'(-pitch_reg) : 17'(pitch_reg);
    assign pdiff     = 19'(pitch_reg) - 19'(setp_s);
    assign pdiff_abs = pdiff[18] ? 18'(-pdiff) : 18'(pdiff);

    // Integral update
    logic        [11:0] q50;
    logic signed [17:0] isum;
    logic signed [16:0] integ_new;
    logic               active;
    assign q50    = prod_reg[RECIP50_SH+11:RECIP50_SH];
    assign isum   = 18'(integ_reg) + (eneg_reg ? -$signed({6'd0, q50}) : $signed({6'd0, q50}));
    assign active = ~lock_reg & en_reg;
    always_comb begin
        if (isum > 18'sd38400) begin
            integ_new = 17'sd38400;
        end else if (isum < -18'sd38400) begin
            integ_new = -17'sd38400;
        end else begin
            integ_new = 17'(isum);
        end
    end

    // Motor command from the PID sum
    logic        [43:0] s_abs;
    logic        [27:0] s_hi;
    logic        [7:0]  mag;
    assign s_abs = sacc_reg[43] ? 44'(-sacc_reg) : 44'(sacc_reg);
    assign s_hi  = s_abs[43:16];
    assign mag   = (s_hi > 28'd255) ? 8'd255 : s_hi[7:0];

    assign status.out_free = ~m_valid_reg | m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg       <= '0;
            integ_reg       <= '0;
            last_err_reg    <= '0;
            lock_reg        <= 1'b1;
            enable_seen_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.step)
                STEP_LOAD: begin
                    ok_reg          <= sample_ok;
                    en_reg          <= motor_enable;
                    enable_seen_reg <= motor_enable;
                    if (motor_enable && !enable_seen_reg) begin
                        lock_reg     <= 1'b0;
                        integ_reg    <= '0;
                        last_err_reg <= '0;
                    end
                    g_reg <= 17'($signed(gyro_y)) - 17'($signed(cfg.gyro_offset));
                    if (accel_z == 16'd0) begin
                        // Vector on the X axis: the angle is known without rotation.
                        hold_reg <= 1'b1;
                        cz_reg   <= accel_x[15] ? 26'sd11796480 : 26'sd0;
                        cx_reg   <= '0;
                        cy_reg   <= '0;
                    end else if (accel_x[15]) begin
                        hold_reg <= 1'b0;
                        cz_reg   <= accel_z[15] ? -26'sd11796480 : 26'sd11796480;
                        cx_reg   <= -(19'($signed(accel_x)));
                        cy_reg   <= -(19'($signed(accel_z)));
                    end else begin
                        hold_reg <= 1'b0;
                        cz_reg   <= '0;
                        cx_reg   <= 19'($signed(accel_x));
                        cy_reg   <= 19'($signed(accel_z));
                    end
                end
                STEP_CORDIC: begin
                    if (!hold_reg) begin
                        if (cy_reg > 19'sd0) begin
                            cx_reg <= cx_reg + ys;
                            cy_reg <= cy_reg - xs;
                            cz_reg <= cz_reg + atan_s;
                        end else begin
                            cx_reg <= cx_reg - ys;
                            cy_reg <= cy_reg + xs;
                            cz_reg <= cz_reg - atan_s;
                        end
                    end
                end
                STEP_ACC: begin
                    acc_reg  <= acc_clamped;
                    prod_reg <= mul_p[43:0];
                end
                STEP_F1: begin
                    d1_reg   <= 32'(prod_reg) - (32'(g_reg) <<< 9);
                    prod_reg <= mul_p[43:0];
                end
                STEP_F2: begin
                    nacc_reg <= 40'(prod_reg);
                    prod_reg <= mul_p[43:0];
                end
                STEP_F3: begin
                    n_reg <= nacc_reg + 40'(prod_reg);
                end
                STEP_F4: begin
                    nneg_reg <= n_reg[39];
                    rem_reg  <= n_abs + 40'(DIV_HALF);
                    quo_reg  <= '0;
                end
                STEP_DIV: begin
                    // The estimate is low by at most one; the last cycle fixes it.
                    if (cmd.iter == '0) begin
                        prod_reg <= mul_p[43:0];
                    end else if (cmd.iter == ITER_W'(1)) begin
                        quo_reg  <= q_est;
                        prod_reg <= mul_p[43:0];
                    end else if ((rem_reg - 40'(prod_reg)) >= 40'(DIV_K)) begin
                        quo_reg <= quo_reg + 1'b1;
                    end
                end
                STEP_PITCH: begin
                    if (ok_reg) begin
                        pitch_reg <= pitch_new;
                    end else begin
                        lock_reg <= 1'b1;
                    end
                end
                STEP_SAFE: begin
                    if (!en_reg) begin
                        lock_reg <= 1'b1;
                    end else if (pitch_abs > 17'(cfg.fall_limit)) begin
                        lock_reg <= 1'b1;
                    end else if (lock_reg && (pdiff_abs < 18'(cfg.recover_limit))) begin
                        lock_reg     <= 1'b0;
                        integ_reg    <= '0;
                        last_err_reg <= '0;
                    end
                    e_reg <= setp_s - 18'(pitch_reg);
                end
                STEP_P1: begin
                    eneg_reg <= e_reg[17];
                    emag_reg <= (e_reg[17] ? 18'(-e_reg) : 18'(e_reg)) + 18'd25;
                    de_reg   <= 19'(e_reg) - 19'(last_err_reg);
                    prod_reg <= mul_p[43:0];
                end
                STEP_P2: begin
                    sacc_reg <= prod_reg;
                    prod_reg <= mul_p[43:0];
                end
                STEP_P3: begin
                    if (active) begin
                        integ_reg <= integ_new;
                    end
                    prod_reg <= mul_p[43:0];
                end
                STEP_P4: begin
                    kd50_reg <= 23'(prod_reg);
                    prod_reg <= mul_p[43:0];
                end
                STEP_P5: begin
                    sacc_reg <= sacc_reg + prod_reg;
                    prod_reg <= mul_p[43:0];
                end
                STEP_P6: begin
                    sacc_reg <= sacc_reg + prod_reg;
                end
                STEP_OUT: begin
                    m_valid_reg   <= 1'b1;
                    out_pitch_reg <= pitch_reg;
                    out_lock_reg  <= lock_reg;
                    if (!active) begin
                        integ_reg    <= '0;
                        last_err_reg <= '0;
                        out_duty_reg <= 8'd0;
                        out_dir_reg  <= DIR_BRAKE;
                    end else begin
                        last_err_reg <= e_reg;
                        if (mag < cfg.dead_band) begin
                            out_duty_reg <= 8'd0;
                            out_dir_reg  <= DIR_BRAKE;
                        end else begin
                            // The output is the negated PID sum.
                            out_duty_reg <= mag;
                            out_dir_reg  <= (!sacc_reg[43] && s_hi != 28'd0) ?
                                            DIR_REVERSE : DIR_FORWARD;
                        end
                    end
                end
                default: begin
                    hold_reg <= hold_reg;
                end
            endcase
        end
    end

    assign m_tvalid    = m_valid_reg;
    assign pitch_angle = out_pitch_reg;
    assign locked      = out_lock_reg;
    assign duty        = out_duty_reg;
    assign direction   = out_dir_reg;

endmodule

`default_nettype wire

// ===== hdl/tilt_balance_pid_controller_unit.sv =====
// Tilt balance PID controller, top level: APB register file, sequencer and
// datapath. Depends on tbpc_pkg, tbpc_cfg_regs, tbpc_ctrl and tbpc_datapath.
//
// Usage:
// - Input stream (s_*): one sensor sample per transfer. s_tdata carries the
//   raw accel X, accel Z and gyro Y words; s_tuser carries the read-ok flag
//   and the motor enable level.
// - Output stream (m_*): one result per sample, with the filtered pitch,
//   PWM duty and direction in m_tdata and the lock flag in m_tuser.
// - Configuration: APB-style port, one 32-bit register per 4 bytes. Write it
//   only while no sample is in flight.
// Sequence: after its transfer a sample goes through the CORDIC iterations,
// the filter steps, the filter divide, the safety check and the PID steps
// to its result being presented. The filter divide forms a reciprocal
// estimate and a back-multiply on the shared multiplier, then a correction.
// One sample is worked on at a time, so the next input transfer can be taken
// in the cycle after the previous result is registered, not before.
// Reset (synchronous, active low) restores the register defaults, zeroes
// the pitch and PID memory and sets the safety lock.
// When the receiver stalls, the result waits in the output register and the next
// sample is held at its output step until that result has been transferred.
`default_nettype none

module tilt_balance_pid_controller_unit
    import tbpc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // accel_x [15:0], accel_z [31:16], gyro_y [47:32]
    input  wire logic [47:0]       s_tdata,
    // sample_ok [0], motor_enable [1]
    input  wire logic [1:0]        s_tuser,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // pitch_angle [16:0], duty [24:17], direction [26:25], zero [31:27]
    output logic      [31:0]       m_tdata,
    // locked [0]
    output logic      [0:0]        m_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic      [31:0]       prdata,
    output logic                   pready
);

    cfg_t        cfg;
    cmd_t        cmd;
    status_t     status;
    logic [16:0] pitch_angle;
    logic        locked;
    logic [7:0]  duty;
    logic [1:0]  direction;

    tbpc_cfg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tbpc_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg          (cfg),
        .accel_x      (s_tdata[15:0]),
        .accel_z      (s_tdata[31:16]),
        .gyro_y       (s_tdata[47:32]),
        .sample_ok    (s_tuser[0]),
        .motor_enable (s_tuser[1]),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .pitch_angle  (pitch_angle),
        .locked       (locked),
        .duty         (duty),
        .direction    (direction),
        .status       (status)
    );

    assign m_tdata = {5'd0, direction, duty, pitch_angle};
    assign m_tuser = locked;

endmodule

`default_nettype wire

// ===== hdl/tbpc_checker.sv =====
// Port-level checks of the tilt balance controller, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module tbpc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [31:0] m_tdata,
    input wire logic [0:0]  m_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);

    // A stalled result keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result present after reset");

    // One sample at a time: no transfer right after a transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while busy");

    // A locked result never drives the motors.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[24:17] == 8'd0 && m_tdata[26:25] == 2'd0)
        else $error("motors driven while locked");

    // Direction code three is never produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[26:25] != 2'd3)
        else $error("invalid direction");

endmodule

bind tilt_balance_pid_controller_unit tbpc_checker u_tbpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench of the tilt balance PID controller top level.
// Depends on tbpc_pkg and tilt_balance_pid_controller_unit; a scoreboard class
// predicts each result from the accepted samples and checks the output stream.
`default_nettype none

class balance_scoreboard;
    logic signed [16:0] pitch;
    logic signed [16:0] integ;
    logic signed [17:0] prev_err;
    bit lock_flag;
    bit en_seen;
    logic [31:0] regs [8];
    logic [31:0] exp_data [$];
    logic        exp_lock [$];
    int mismatches;

    function void clear_state();
        pitch = 0;
        integ = 0;
        prev_err = 0;
        lock_flag = 1;
        en_seen = 0;
        regs[0] = 0;
        regs[1] = 32'h1FC00;
        regs[2] = 23040;
        regs[3] = 1280;
        regs[4] = 0;
        regs[5] = 7680;
        regs[6] = 3840;
        regs[7] = 210;
        mismatches = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] val);
        int w[8] = '{16, 17, 16, 16, 16, 16, 16, 8};
        regs[idx] = val & ((64'd1 << w[idx]) - 1);
    endfunction

    static function longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    static function longint div_near(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    static function longint clip(longint v, longint lim);
        if (v > lim)
            return lim;
        if (v < -lim)
            return -lim;
        return v;
    endfunction

    static function longint atan_deg16(longint y, longint x);
        longint z, xs, ys;
        int n;
        z = 0;
        if (y == 0)
            return (x < 0) ? tbpc_pkg::DEG180 : 0;
        if (x < 0) begin
            z = (y >= 0) ? tbpc_pkg::DEG180 : -tbpc_pkg::DEG180;
            x = -x;
            y = -y;
        end
        n = (tbpc_pkg::CORDIC_STEPS < 24) ? tbpc_pkg::CORDIC_STEPS : 24;
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z += tbpc_pkg::atan_angle(i[4:0]);
            end else begin
                x = x - ys;
                y = y + xs;
                z -= tbpc_pkg::atan_angle(i[4:0]);
            end
        end
        return z;
    endfunction

    function void note_sample(logic [47:0] d, logic [1:0] u);
        longint ax, az, gy, acc, g, num, p, sp, e, s, speed, mag, ap, dv;
        bit ok, en;
        logic [7:0] duty;
        logic [1:0] dir;
        logic [16:0] p17;
        ax = $signed(d[15:0]);
        az = $signed(d[31:16]);
        gy = $signed(d[47:32]);
        ok = u[0];
        en = u[1];
        sp = $signed(regs[1][16:0]);
        duty = 0;
        dir = tbpc_pkg::DIR_BRAKE;
        if (en && !en_seen) begin
            lock_flag = 0;
            integ = 0;
            prev_err = 0;
        end
        en_seen = en;
        p = pitch;
        if (ok) begin
            acc = clip(-shr_floor(atan_deg16(az, ax) + 128, 8), tbpc_pkg::PITCH_MAX);
            g = gy - longint'($signed(regs[0][15:0]));
            num = 98 * (13100 * p - 512 * g) + 26200 * acc;
            p = clip(div_near(num, 1310000), tbpc_pkg::PITCH_MAX);
            pitch = p;
        end else begin
            lock_flag = 1;
        end
        ap = (p < 0) ? -p : p;
        dv = (p - sp < 0) ? sp - p : p - sp;
        if (!en)
            lock_flag = 1;
        else if (ap > longint'(regs[5]))
            lock_flag = 1;
        else if (lock_flag && dv < longint'(regs[6])) begin
            lock_flag = 0;
            integ = 0;
            prev_err = 0;
        end
        if (lock_flag || !en) begin
            integ = 0;
            prev_err = 0;
        end else begin
            e = sp - p;
            integ = clip(longint'(integ) + div_near(e, 50), tbpc_pkg::INTEG_MAX);
            s = longint'(regs[2]) * e + longint'(regs[3]) * longint'(integ)
                + longint'(regs[4]) * 50 * (e - longint'(prev_err));
            prev_err = e;
            speed = clip(-(s / 65536), 255);
            mag = (speed < 0) ? -speed : speed;
            if (mag >= longint'(regs[7])) begin
                duty = mag;
                dir = (speed < 0) ? tbpc_pkg::DIR_REVERSE : tbpc_pkg::DIR_FORWARD;
            end
        end
        p17 = p;
        exp_data.push_back({5'd0, dir, duty, p17});
        exp_lock.push_back(lock_flag);
    endfunction

    function void check_result(logic [31:0] d, logic lk);
        logic [31:0] ed;
        logic el;
        if (exp_data.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result data=%h locked=%b", d, lk);
            return;
        end
        ed = exp_data.pop_front();
        el = exp_lock.pop_front();
        if (d !== ed || lk !== el) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"result mismatch: pitch exp %0d got %0d, duty exp %0d got %0d,",
                          " dir exp %0d got %0d, locked exp %b got %b"},
                         $signed(ed[16:0]), $signed(d[16:0]), ed[24:17], d[24:17],
                         ed[26:25], d[26:25], el, lk);
        end
    endfunction
endclass

module testbench;
    import tbpc_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk;
    logic        aresetn;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    balance_scoreboard board;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  cycles;
    bit  en_level;

    tilt_balance_pid_controller_unit u_dut (
        .aclk, .aresetn, .s_tdata, .s_tuser, .s_tvalid, .s_tready,
        .m_tdata, .m_tuser, .m_tvalid, .m_tready,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_off is set.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 0;
        else
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready)
            board.check_result(m_tdata, m_tuser[0]);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        board.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [47:0] d, input logic [1:0] u);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge aclk);
        s_tdata <= d;
        s_tuser <= u;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        board.note_sample(d, u);
        s_tvalid <= 0;
        // The block is busy right after a transfer, so this cycle costs nothing.
        @(posedge aclk);
    endtask

    task automatic drain();
        while (board.exp_data.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    // Mostly plausible tilts near upright, with some full-range noise.
    task automatic random_sample();
        logic [15:0] ax, az, gy;
        logic ok;
        int r;
        r = $urandom_range(99);
        if (r < 75) begin
            ax = $signed($urandom_range(6000)) - 3000;
            az = 16384 + $urandom_range(4000) - 2000;
            gy = $signed($urandom_range(2000)) - 1000;
        end else begin
            ax = $urandom;
            az = $urandom;
            gy = $urandom;
        end
        ok = ($urandom_range(99) < 95);
        if ($urandom_range(99) < 3)
            en_level = !en_level;
        else if (!en_level && $urandom_range(99) < 30)
            en_level = 1;
        send_sample({gy, az, ax}, {en_level, ok});
    endtask

    task automatic random_config(input bit extreme);
        write_reg(REG_GYRO_OFFSET, extreme ? 32'h8000 : ($urandom_range(400) - 200));
        write_reg(REG_SETPOINT, extreme ? (($urandom_range(1)) ? 32'd46080 : -32'sd46080)
                                        : ($urandom_range(4000) - 2000));
        write_reg(REG_PROP_GAIN, extreme ? 32'hFFFF : $urandom_range(30000));
        write_reg(REG_INTEGRAL_GAIN, extreme ? 32'hFFFF : $urandom_range(5000));
        write_reg(REG_DERIV_GAIN, extreme ? 32'hFFFF : $urandom_range(3000));
        write_reg(REG_FALL_LIMIT, extreme ? 32'd46080 : $urandom_range(4000, 12000));
        write_reg(REG_RECOVER_LIMIT, extreme ? 32'd46080 : $urandom_range(1000, 6000));
        write_reg(REG_DEAD_BAND, extreme ? 32'd0 : $urandom_range(255));
    endtask

    initial begin
        logic [15:0] vals [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h4000};
        int pct [4] = '{0, 60, 0, 14};
        int rst [4] = '{0, 0, 60, 14};
        board = new();
        board.clear_state();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        en_level = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: axis extremes, zero axes, read fault, enable edges.
        send_sample({16'd0, 16'd16384, 16'd100}, 2'b11);
        send_sample({16'd0, 16'd0, 16'd0}, 2'b11);
        send_sample({16'd0, 16'd0, 16'hFF00}, 2'b11);
        send_sample({16'd0, 16'd0, 16'd500}, 2'b11);
        for (int i = 0; i < 6; i++)
            send_sample({vals[(i + 2) % 6], vals[i], vals[(i + 1) % 6]}, 2'b11);
        send_sample({16'h1234, 16'd500, 16'd20}, 2'b10);
        send_sample({16'h8000, 16'h7FFF, 16'h8000}, 2'b01);
        send_sample({16'h7FFF, 16'h8000, 16'h7FFF}, 2'b11);
        send_sample({16'd0, 16'd16384, 16'd0}, 2'b00);
        drain();
        random_config(1);
        write_reg(REG_SETPOINT, 0);
        send_sample({16'd0, 16'd16384, 16'd0}, 2'b11);
        send_sample({16'd0, 16'd16384, 16'd0}, 2'b11);
        send_sample({16'd0, 16'd16384, 16'hFFFF}, 2'b11);
        en_level = 1;
        drain();
        write_reg(REG_SETPOINT, -32'sd46080);

        for (int ph = 0; ph < 5; ph++) begin
            drain();
            random_config(ph == 2);
            send_idle_pct = pct[ph % 4];
            recv_stall_pct = rst[ph % 4];
            for (int n = 0; n < 240; n++) begin
                if (ph == 1 && n == 50)
                    hold_off = 1;
                if (ph == 1 && n == 55)
                    hold_off = 0;
                if (ph == 3 && n == 100)
                    while (board.exp_data.size() != 0)
                        @(posedge aclk);
                random_sample();
            end
        end
        drain();
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Long receiver hold-off: started by the stimulus and ended by this block.
    initial begin
        wait (hold_off);
        repeat (400) @(posedge aclk);
        hold_off = 0;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
hdl/tbpc_pkg.sv
hdl/tbpc_cfg_regs.sv
hdl/tbpc_ctrl.sv
hdl/tbpc_datapath.sv
hdl/tilt_balance_pid_controller_unit.sv
hdl/tbpc_checker.sv
sim/testbench.sv
